### rtl/core/gcsf_pkg.sv
package gcsf_pkg;

  // Ring geometry and request limits
  localparam int DEPTH   = 8192;
  localparam int MAX_POP = 64;
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);

  // Field widths
  localparam int SMP_W   = 16;
  localparam int FRM_W   = 7;
  localparam int PROD_W  = 2 * SMP_W;
  localparam int FRAC_W  = 12;
  localparam int CMP_W   = (CNT_W > FRM_W) ? CNT_W : FRM_W;

  localparam logic signed [SMP_W-1:0] GAIN_UNITY = 16'sd4096;
  localparam logic signed [SMP_W-1:0] SMP_MAX    = 16'sh7fff;
  localparam logic signed [SMP_W-1:0] SMP_MIN    = 16'sh8000;

  // Request codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic push_commit;
    logic empty_emit;
    logic pop_read;
    logic pop_emit;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_free;
    logic take_zero;
    logic pop_last;
  } sts_t;

  // Advance a ring pointer with wrap
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
    logic [PTR_W-1:0] res;
    if (ptr == PTR_W'(DEPTH - 1)) begin
      res = '0;
    end else begin
      res = ptr + PTR_W'(1);
    end
    return res;
  endfunction

endpackage

### rtl/core/gcsf_ram.sv
module gcsf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port, registered read port that holds when not enabled
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/core/gcsf_ctrl.sv
module gcsf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_op,
  output logic           in_stall,
  input  gcsf_pkg::sts_t sts,
  output gcsf_pkg::cmd_t cmd
);
  import gcsf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_EMPTY,
    ST_POP_RD,
    ST_POP_EMIT
  } state_t;

  state_t state_r, state_nxt;

  // Sequence one request at a time
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (in_op == OP_PUSH) begin
            state_nxt = ST_PUSH;
          end else if (sts.take_zero) begin
            state_nxt = ST_EMPTY;
          end else begin
            state_nxt = ST_POP_RD;
          end
        end
      end
      ST_PUSH: begin
        if (sts.out_free) begin
          cmd.push_commit = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      ST_EMPTY: begin
        if (sts.out_free) begin
          cmd.empty_emit = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      ST_POP_RD: begin
        cmd.pop_read = 1'b1;
        state_nxt    = ST_POP_EMIT;
      end
      ST_POP_EMIT: begin
        if (sts.out_free) begin
          cmd.pop_emit = 1'b1;
          if (sts.pop_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule

### rtl/core/gcsf_dp.sv
module gcsf_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic signed [gcsf_pkg::SMP_W-1:0]    cfg_wr_data,
  input  logic signed [gcsf_pkg::SMP_W-1:0]    in_sample_in,
  input  logic        [gcsf_pkg::FRM_W-1:0]    in_frames_wanted,
  input  gcsf_pkg::cmd_t                       cmd,
  output gcsf_pkg::sts_t                       sts,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [gcsf_pkg::SMP_W-1:0]    out_sample_out,
  output logic                                 out_has_data,
  output logic                                 out_dropped_oldest,
  output logic                                 out_last,
  output logic        [gcsf_pkg::CNT_W-1:0]    out_fill_level
);
  import gcsf_pkg::*;

  logic signed [SMP_W-1:0]  gain_r, gain_nxt;
  logic [PTR_W-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [FRM_W-1:0]         rem_r, rem_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic signed [SMP_W-1:0]  out_sample_r, out_sample_nxt;
  logic                     out_has_r, out_has_nxt;
  logic                     out_drop_r, out_drop_nxt;
  logic                     out_last_r, out_last_nxt;
  logic [CNT_W-1:0]         out_fill_r, out_fill_nxt;

  logic [FRM_W-1:0]         want_sat;
  logic [CMP_W-1:0]         want_ext;
  logic [CMP_W-1:0]         cnt_ext;
  logic [CMP_W-1:0]         take_ext;
  logic                     full;
  logic signed [PROD_W-1:0] shifted;
  logic signed [SMP_W-1:0]  scaled;
  logic [SMP_W-1:0]         rd_data;
  logic                     ram_rd_en;
  logic                     load;

  // Clamp the request and bound it by the fill
  assign want_sat = (in_frames_wanted > FRM_W'(MAX_POP)) ? FRM_W'(MAX_POP) : in_frames_wanted;
  assign want_ext = CMP_W'(want_sat);
  assign cnt_ext  = CMP_W'(count_r);
  assign take_ext = (cnt_ext < want_ext) ? cnt_ext : want_ext;

  assign full = (count_r == CNT_W'(DEPTH));

  // Scale: floor shift of the registered product, then saturate
  assign prod_nxt = in_sample_in * gain_r;
  assign shifted  = prod_r >>> FRAC_W;
  always_comb begin
    if (shifted > PROD_W'(SMP_MAX)) begin
      scaled = SMP_MAX;
    end else if (shifted < PROD_W'(SMP_MIN)) begin
      scaled = SMP_MIN;
    end else begin
      scaled = shifted[SMP_W-1:0];
    end
  end

  assign load = cmd.push_commit | cmd.empty_emit | cmd.pop_emit;

  // Advance pointers, count, remaining frames and gain
  always_comb begin
    gain_nxt   = cfg_wr_en ? cfg_wr_data : gain_r;
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    count_nxt  = count_r;
    rem_nxt    = rem_r;
    if (cmd.capture) begin
      rem_nxt = take_ext[FRM_W-1:0];
    end
    if (cmd.push_commit) begin
      wr_ptr_nxt = ptr_inc(wr_ptr_r);
      if (full) begin
        rd_ptr_nxt = ptr_inc(rd_ptr_r);
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end
    if (cmd.pop_emit) begin
      rd_ptr_nxt = ptr_inc(rd_ptr_r);
      count_nxt  = count_r - CNT_W'(1);
      rem_nxt    = rem_r - FRM_W'(1);
    end
  end

  // Build the next result
  always_comb begin
    out_sample_nxt = out_sample_r;
    out_has_nxt    = out_has_r;
    out_drop_nxt   = out_drop_r;
    out_last_nxt   = out_last_r;
    out_fill_nxt   = out_fill_r;
    if (load) begin
      out_sample_nxt = cmd.pop_emit ? $signed(rd_data) : '0;
      out_has_nxt    = cmd.pop_emit;
      out_drop_nxt   = cmd.push_commit & full;
      out_last_nxt   = cmd.pop_emit ? sts.pop_last : 1'b1;
      out_fill_nxt   = count_nxt;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r      <= GAIN_UNITY;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      count_r     <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      gain_r      <= gain_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      count_r     <= count_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      prod_r <= prod_nxt;
    end
    out_sample_r <= out_sample_nxt;
    out_has_r    <= out_has_nxt;
    out_drop_r   <= out_drop_nxt;
    out_last_r   <= out_last_nxt;
    out_fill_r   <= out_fill_nxt;
  end

  // Read ahead at the next read pointer so frames stream each cycle while the output is not stalled
  assign ram_rd_en = cmd.pop_read | cmd.pop_emit;

  gcsf_ram #(
    .WIDTH (SMP_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.push_commit),
    .wr_addr (wr_ptr_r),
    .wr_data (scaled),
    .rd_en   (ram_rd_en),
    .rd_addr (rd_ptr_nxt),
    .rd_data (rd_data)
  );

  assign sts.out_free  = ~out_valid_r | ~out_stall;
  assign sts.take_zero = (take_ext == '0);
  assign sts.pop_last  = (rem_r == FRM_W'(1));

  assign out_valid          = out_valid_r;
  assign out_sample_out     = out_sample_r;
  assign out_has_data       = out_has_r;
  assign out_dropped_oldest = out_drop_r;
  assign out_last           = out_last_r;
  assign out_fill_level     = out_fill_r;

endmodule

### rtl/core/gain_clamp_sample_fifo_drop_oldest_top.sv
// Push: the product is registered when the request is taken; the ring write and the
// result follow once the output is free. Pop of n frames: the store is read, then one
// frame per cycle while the output is not stalled, from the single read port of the
// sample store. Empty pop: one result once the output is free. Requests do not overlap.
// Synchronous active-low reset clears pointers, fill count and output valid, and sets the
// gain to unity; stored samples are not cleared and are read only after being written.
module gain_clamp_sample_fifo_drop_oldest_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic signed [gcsf_pkg::SMP_W-1:0]    cfg_wr_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_op,
  input  logic signed [gcsf_pkg::SMP_W-1:0]    in_sample_in,
  input  logic        [gcsf_pkg::FRM_W-1:0]    in_frames_wanted,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [gcsf_pkg::SMP_W-1:0]    out_sample_out,
  output logic                                 out_has_data,
  output logic                                 out_dropped_oldest,
  output logic                                 out_last,
  output logic        [gcsf_pkg::CNT_W-1:0]    out_fill_level
);
  import gcsf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  gcsf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  gcsf_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_sample_in       (in_sample_in),
    .in_frames_wanted   (in_frames_wanted),
    .cmd                (cmd),
    .sts                (sts),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_sample_out     (out_sample_out),
    .out_has_data       (out_has_data),
    .out_dropped_oldest (out_dropped_oldest),
    .out_last           (out_last),
    .out_fill_level     (out_fill_level)
  );

  // Fill never exceeds the ring depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_fill_level <= CNT_W'(DEPTH)))
    else $error("fill level above depth");

  // A popped frame never reports a drop
  a_pop_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_has_data) |-> !out_dropped_oldest)
    else $error("drop flag on popped frame");

  // A result without data always closes its request
  a_nodata_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_has_data) |-> out_last)
    else $error("result without data not marked last");

  // A taken request stalls the input in the cycle after it is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request taken back to back");

endmodule
